@@ design/rpu_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package rpu_pkg;

	// Block size and field widths
	localparam int MAX_BLOCK_DEF = 512;
	localparam int OFF_W         = 10;
	localparam int PIDX_W        = 5;
	localparam int CFG_IDX_W     = 2;
	localparam int FIFO_DEPTH    = 2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_TYPE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DIGEST_MODE = 2'd1;

	// Digest modes
	localparam logic [1:0] DM_NONE   = 2'd0;
	localparam logic [1:0] DM_SHA1   = 2'd1;
	localparam logic [1:0] DM_SHA256 = 2'd2;

	localparam logic [1:0] BT_SIGN = 2'd1;
	localparam logic [7:0] FILL_FF = 8'hff;

	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_HEADER = 3'd1,
		ST_FILL   = 3'd2,
		ST_NOSEP  = 3'd3,
		ST_PREFIX = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		PH_LEAD    = 3'd0,
		PH_TYPE    = 3'd1,
		PH_FILL    = 3'd2,
		PH_PREFIX  = 3'd3,
		PH_PAYLOAD = 3'd4,
		PH_FAILED  = 3'd5
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [2:0]       status;
		logic [OFF_W-1:0] payload_offset;
	} out_item_t;

	// Classified byte, front to back
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
		logic       is_zero;
		logic       type_ok;
		logic       fill_bad;
	} cls_item_t;

	// DigestInfo prefix length for a digest mode
	function automatic logic [PIDX_W-1:0] prefix_len(input logic [1:0] mode);
		logic [PIDX_W-1:0] len;
		case (mode)
			DM_SHA1:   len = 5'd15;
			DM_SHA256: len = 5'd19;
			default:   len = 5'd0;
		endcase
		return len;
	endfunction

	// DigestInfo prefix byte i for a digest mode
	function automatic logic [7:0] prefix_byte(input logic [1:0] mode,
						    input logic [PIDX_W-1:0] i);
		logic [7:0] b;
		b = 8'h00;
		if (mode == DM_SHA1) begin
			case (i)
				5'd0:    b = 8'h30;
				5'd1:    b = 8'h21;
				5'd2:    b = 8'h30;
				5'd3:    b = 8'h09;
				5'd4:    b = 8'h06;
				5'd5:    b = 8'h05;
				5'd6:    b = 8'h2b;
				5'd7:    b = 8'h0e;
				5'd8:    b = 8'h03;
				5'd9:    b = 8'h02;
				5'd10:   b = 8'h1a;
				5'd11:   b = 8'h05;
				5'd12:   b = 8'h00;
				5'd13:   b = 8'h04;
				5'd14:   b = 8'h14;
				default: b = 8'h00;
			endcase
		end else if (mode == DM_SHA256) begin
			case (i)
				5'd0:    b = 8'h30;
				5'd1:    b = 8'h31;
				5'd2:    b = 8'h30;
				5'd3:    b = 8'h0d;
				5'd4:    b = 8'h06;
				5'd5:    b = 8'h09;
				5'd6:    b = 8'h60;
				5'd7:    b = 8'h86;
				5'd8:    b = 8'h48;
				5'd9:    b = 8'h01;
				5'd10:   b = 8'h65;
				5'd11:   b = 8'h03;
				5'd12:   b = 8'h04;
				5'd13:   b = 8'h02;
				5'd14:   b = 8'h01;
				5'd15:   b = 8'h05;
				5'd16:   b = 8'h00;
				5'd17:   b = 8'h04;
				5'd18:   b = 8'h20;
				default: b = 8'h00;
			endcase
		end
		return b;
	endfunction

endpackage

`default_nettype wire

@@ design/rsa_pkcs1_unpad_checker.sv @@
//  channel | signals                          | transfer when
//  --------+----------------------------------+----------------------
//  in      | in_valid, in_ready, in_data      | in_valid && in_ready
//  out     | out_valid, out_ready, out_data   | out_valid && out_ready
//  cfg     | cfg_valid, cfg_ready, cfg_index, | cfg_valid && cfg_ready
//          | cfg_data                         |
//
//  One byte per cycle while the queue has room; after its last byte transfers,
//  a result passes through the queue and is then held in the output register.
//  The two-entry queue lets the byte input run while the output stalls;
//  only a last byte waits for the output register to free up.
//  Asynchronous reset clears parse state, queue and config (block_type 1).
//  cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none

module rsa_pkcs1_unpad_checker import rpu_pkg::*; #(
	parameter int MAX_BLOCK = MAX_BLOCK_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire in_item_t             in_data,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output out_item_t                 out_data,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [1:0]           cfg_data
);

	logic [1:0] block_type_q;
	logic [1:0] digest_mode_q;
	cls_item_t  cls_item;
	cls_item_t  head;
	logic       fifo_full;
	logic       fifo_empty;
	logic       fifo_pop;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_type_q  <= BT_SIGN;
			digest_mode_q <= DM_NONE;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_BLOCK_TYPE) begin
				block_type_q <= cfg_data;
			end else if (cfg_index == CFG_DIGEST_MODE) begin
				digest_mode_q <= cfg_data;
			end
		end
	end

	// Front: classify incoming bytes
	rpu_front u_front (
		.block_type (block_type_q),
		.in_item    (in_data),
		.cls_item   (cls_item)
	);

	assign in_ready = !fifo_full;

	// Queue between front and back
	rpu_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_valid),
		.push_item (cls_item),
		.full      (fifo_full),
		.pop       (fifo_pop),
		.empty     (fifo_empty),
		.head      (head)
	);

	// Back: parse state machine and result register
	rpu_back #(
		.MAX_BLOCK (MAX_BLOCK)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.digest_mode (digest_mode_q),
		.fifo_empty  (fifo_empty),
		.fifo_head   (head),
		.fifo_pop    (fifo_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_item    (out_data)
	);

endmodule

`default_nettype wire

@@ design/rpu_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rpu_front import rpu_pkg::*; (
	input  wire logic      [1:0] block_type,
	input  wire in_item_t        in_item,
	output cls_item_t            cls_item
);

	// Per-byte compares that need no parse state
	always_comb begin
		cls_item.data_byte = in_item.data_byte;
		cls_item.last_byte = in_item.last_byte;
		cls_item.is_zero   = (in_item.data_byte == 8'h00);
		cls_item.type_ok   = (in_item.data_byte == {6'b0, block_type});
		cls_item.fill_bad  = (block_type == BT_SIGN) && (in_item.data_byte != FILL_FF);
	end

endmodule

`default_nettype wire

@@ design/rpu_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rpu_fifo import rpu_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire cls_item_t push_item,
	output logic           full,
	input  wire logic      pop,
	output logic           empty,
	output cls_item_t      head
);

	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(FIFO_DEPTH - 1);

	cls_item_t        mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(FIFO_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

@@ design/rpu_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rpu_back import rpu_pkg::*; #(
	parameter int MAX_BLOCK = MAX_BLOCK_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic [1:0] digest_mode,
	input  wire logic      fifo_empty,
	input  wire cls_item_t fifo_head,
	output logic           fifo_pop,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_item_t      out_item
);

	localparam int POS_W = $clog2(MAX_BLOCK + 1);
	localparam int SUM_W = ((POS_W > OFF_W) ? POS_W : OFF_W) + 1;
	localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_BLOCK);

	phase_t            phase_q, phase_d;
	status_t           err_q, err_d;
	logic [POS_W-1:0]  pos_q, pos_d;
	logic [POS_W-1:0]  sep_q, sep_d;
	logic [PIDX_W-1:0] pidx_q, pidx_d;
	logic              out_valid_q;
	out_item_t         out_q;

	logic              examine;
	logic [PIDX_W-1:0] plen;
	logic [PIDX_W-1:0] pidx_inc;
	logic              prefix_covered;
	logic              prefix_hit;
	phase_t            phase_ex;
	status_t           err_ex;
	logic [PIDX_W-1:0] pidx_ex;
	logic [POS_W-1:0]  sep_ex;
	logic [SUM_W-1:0]  off_sum;
	out_item_t         result;

	// Pop when the byte can finish: only a last byte needs the output slot
	assign fifo_pop = !fifo_empty &&
			  (!fifo_head.last_byte || !out_valid_q || out_ready);
	assign examine  = (pos_q < POS_MAX);

	// Prefix compare
	assign plen           = prefix_len(digest_mode);
	assign pidx_inc       = pidx_q + 1'b1;
	assign prefix_covered = (pidx_q >= plen);
	assign prefix_hit     = (fifo_head.data_byte == prefix_byte(digest_mode, pidx_q));

	// Parse phase and first error after this byte, then rearm on the last byte
	always_comb begin
		phase_ex = phase_q;
		err_ex   = err_q;
		if (fifo_pop && examine) begin
			case (phase_q)
				PH_LEAD: begin
					if (fifo_head.is_zero) begin
						phase_ex = PH_TYPE;
					end else begin
						phase_ex = PH_FAILED;
						err_ex   = ST_HEADER;
					end
				end
				PH_TYPE: begin
					if (fifo_head.type_ok) begin
						phase_ex = PH_FILL;
					end else begin
						phase_ex = PH_FAILED;
						err_ex   = ST_HEADER;
					end
				end
				PH_FILL: begin
					if (fifo_head.is_zero) begin
						phase_ex = (plen != '0) ? PH_PREFIX : PH_PAYLOAD;
					end else if (fifo_head.fill_bad) begin
						phase_ex = PH_FAILED;
						err_ex   = ST_FILL;
					end
				end
				PH_PREFIX: begin
					if (prefix_covered) begin
						phase_ex = PH_PAYLOAD;
					end else if (!prefix_hit) begin
						phase_ex = PH_FAILED;
						err_ex   = ST_PREFIX;
					end else if (pidx_inc >= plen) begin
						phase_ex = PH_PAYLOAD;
					end
				end
				default: begin
					phase_ex = phase_q;
				end
			endcase
		end
		phase_d = phase_ex;
		err_d   = err_ex;
		// Rearm after the last byte
		if (fifo_pop && fifo_head.last_byte) begin
			phase_d = PH_LEAD;
			err_d   = ST_OK;
		end
	end

	// Position, separator and prefix counters
	always_comb begin
		sep_ex  = sep_q;
		pidx_ex = pidx_q;
		if (fifo_pop && examine) begin
			if (phase_q == PH_FILL && fifo_head.is_zero) begin
				sep_ex  = pos_q;
				pidx_ex = '0;
			end else if (phase_q == PH_PREFIX && !prefix_covered && prefix_hit) begin
				pidx_ex = pidx_inc;
			end
		end
		sep_d  = sep_ex;
		pidx_d = pidx_ex;
		pos_d  = (fifo_pop && examine) ? pos_q + 1'b1 : pos_q;
		if (fifo_pop && fifo_head.last_byte) begin
			sep_d  = '0;
			pidx_d = '0;
			pos_d  = '0;
		end
	end

	// Result of a block, from the state after its last byte
	always_comb begin
		off_sum = SUM_W'(sep_ex) + SUM_W'(1) + SUM_W'(pidx_ex);
		result.payload_offset = '0;
		case (phase_ex)
			PH_FAILED:  result.status = err_ex;
			PH_LEAD,
			PH_TYPE:    result.status = ST_HEADER;
			PH_FILL:    result.status = ST_NOSEP;
			PH_PREFIX:  result.status = ST_PREFIX;
			default: begin
				result.status         = ST_OK;
				result.payload_offset = off_sum[OFF_W-1:0];
			end
		endcase
	end

	// Parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEAD;
			err_q   <= ST_OK;
			pos_q   <= '0;
			sep_q   <= '0;
			pidx_q  <= '0;
		end else begin
			phase_q <= phase_d;
			err_q   <= err_d;
			pos_q   <= pos_d;
			sep_q   <= sep_d;
			pidx_q  <= pidx_d;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fifo_pop && fifo_head.last_byte) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fifo_pop && fifo_head.last_byte) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

`default_nettype wire

@@ verif/rsa_pkcs1_unpad_checker_test.sv @@
`timescale 1ns / 1ps

module rsa_pkcs1_unpad_checker_test;
	import rpu_pkg::*;

	// Idle cycles with no transfer on any channel before the run is called hung
	localparam int QUIET_LIMIT  = 3000;
	// Margin on top of the wait for every result to come back
	localparam int DRAIN_CYCLES = 4;
	localparam int RANDOM_BYTES = 850;
	// Index with no register behind it; a write there must change nothing
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	// DigestInfo prefixes, first byte in the top bits
	localparam logic [119:0] SHA1_INFO = {
		8'h30, 8'h21, 8'h30, 8'h09, 8'h06, 8'h05, 8'h2b, 8'h0e,
		8'h03, 8'h02, 8'h1a, 8'h05, 8'h00, 8'h04, 8'h14
	};
	localparam logic [151:0] SHA256_INFO = {
		8'h30, 8'h31, 8'h30, 8'h0d, 8'h06, 8'h09, 8'h60, 8'h86, 8'h48, 8'h01,
		8'h65, 8'h03, 8'h04, 8'h02, 8'h01, 8'h05, 8'h00, 8'h04, 8'h20
	};

	typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t              kind;
		in_item_t               item;
		logic                   typed;
		out_item_t              result;
		logic [CFG_IDX_W-1:0]   reg_idx;
		logic [1:0]             reg_val;
	} dir_row_t;

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	in_item_t             in_data   = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	out_item_t            out_data;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [1:0]           cfg_data  = '0;

	rsa_pkcs1_unpad_checker uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Shadow configuration and parser state
	logic [1:0]        want_type   = BT_SIGN;
	logic [1:0]        want_digest = DM_NONE;
	logic [OFF_W-1:0]  pos;
	logic [OFF_W-1:0]  sep_at;
	logic [PIDX_W-1:0] pidx;
	phase_t            phase;
	status_t           err;

	out_item_t pending_results[$];
	dir_row_t  dir_rows[$];
	logic [7:0] blk_bytes[$];

	bit idle_on;
	bit stall_on;
	int ready_hold;
	int mismatches;
	int bytes_sent;
	int results_seen;
	int cfg_writes;
	int status_hits[5];

	function automatic int info_len(input logic [1:0] mode);
		if (mode == DM_SHA1)
			return 15;
		if (mode == DM_SHA256)
			return 19;
		return 0;
	endfunction

	function automatic logic [7:0] info_byte(input logic [1:0] mode, input int i);
		if (mode == DM_SHA1 && i < 15)
			return SHA1_INFO[(14 - i) * 8 +: 8];
		if (mode == DM_SHA256 && i < 19)
			return SHA256_INFO[(18 - i) * 8 +: 8];
		return 8'h00;
	endfunction

	task automatic clear_parse();
		pos    = '0;
		sep_at = '0;
		pidx   = '0;
		phase  = PH_LEAD;
		err    = ST_OK;
	endtask

	// Advance the shadow parser by one byte; a last byte yields a verdict
	task automatic parse_byte(input in_item_t it, output bit done, output out_item_t res);
		int plen;
		plen = info_len(want_digest);
		done = 1'b0;
		res  = '0;
		if (pos < MAX_BLOCK_DEF) begin
			case (phase)
				PH_LEAD: begin
					if (it.data_byte != 8'h00) begin
						err   = ST_HEADER;
						phase = PH_FAILED;
					end else
						phase = PH_TYPE;
				end
				PH_TYPE: begin
					if (it.data_byte != {6'd0, want_type}) begin
						err   = ST_HEADER;
						phase = PH_FAILED;
					end else
						phase = PH_FILL;
				end
				PH_FILL: begin
					if (it.data_byte == 8'h00) begin
						sep_at = pos;
						pidx   = '0;
						phase  = (plen != 0) ? PH_PREFIX : PH_PAYLOAD;
					end else if (want_type == BT_SIGN && it.data_byte != FILL_FF) begin
						err   = ST_FILL;
						phase = PH_FAILED;
					end
				end
				PH_PREFIX: begin
					if (pidx >= plen)
						phase = PH_PAYLOAD;
					else if (it.data_byte != info_byte(want_digest, pidx)) begin
						err   = ST_PREFIX;
						phase = PH_FAILED;
					end else begin
						pidx = pidx + 1'b1;
						if (pidx >= plen)
							phase = PH_PAYLOAD;
					end
				end
				default: ;
			endcase
			pos = pos + 1'b1;
		end
		if (it.last_byte) begin
			done = 1'b1;
			if (err != ST_OK)
				res.status = err;
			else begin
				case (phase)
					PH_LEAD, PH_TYPE: res.status = ST_HEADER;
					PH_FILL:          res.status = ST_NOSEP;
					PH_PREFIX:        res.status = ST_PREFIX;
					default: begin
						res.status         = ST_OK;
						res.payload_offset = sep_at + 1'b1
							+ {{(OFF_W - PIDX_W){1'b0}}, pidx};
					end
				endcase
			end
			clear_parse();
		end
	endtask

	// Mostly short gaps, a few long ones
	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic dir_row_t byte_row(input logic [7:0] d);
		dir_row_t row;
		row = '0;
		row.kind = ROW_BYTE;
		row.item.data_byte = d;
		return row;
	endfunction

	function automatic dir_row_t end_row(input logic [7:0] d, input status_t st,
					     input logic [OFF_W-1:0] off);
		dir_row_t row;
		row = '0;
		row.kind = ROW_BYTE;
		row.item.data_byte = d;
		row.item.last_byte = 1'b1;
		row.typed = 1'b1;
		row.result.status = st;
		row.result.payload_offset = off;
		return row;
	endfunction

	function automatic dir_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
					     input logic [1:0] val);
		dir_row_t row;
		row = '0;
		row.kind = ROW_CFG;
		row.reg_idx = idx;
		row.reg_val = val;
		return row;
	endfunction

	// Append one byte to the block under construction
	task automatic add_byte(input logic [7:0] b);
		blk_bytes.insert(blk_bytes.size(), b);
	endtask

	// Append one row to the directed table
	task automatic add_row(input dir_row_t row);
		dir_rows.insert(dir_rows.size(), row);
	endtask

	// One byte transfer; the verdict is queued at the accepting edge
	task automatic send_byte(input in_item_t it, input bit typed, input out_item_t typed_res);
		int gap;
		bit done;
		out_item_t res;
		gap = idle_on ? idle_gap() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		parse_byte(it, done, res);
		bytes_sent++;
		if (done)
			pending_results.insert(pending_results.size(), typed ? typed_res : res);
	endtask

	// hold keeps valid up for a second transfer right behind this one
	task automatic cfg_transfer(input logic [CFG_IDX_W-1:0] idx, input logic [1:0] val,
				    input bit hold);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (!hold)
			cfg_valid <= 1'b0;
		if (idx == CFG_BLOCK_TYPE)
			want_type = val;
		else if (idx == CFG_DIGEST_MODE)
			want_digest = val;
		cfg_writes++;
	endtask

	// Sender holds off until every verdict is back and the queue has emptied
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Well-formed block for the current setting, sometimes damaged
	task automatic build_block(input bit overlong);
		int fill_n, pre_n, pay_n, plen, damage, k;
		blk_bytes.delete();
		plen   = info_len(want_digest);
		fill_n = overlong ? $urandom_range(500, 530) : $urandom_range(0, 10);
		pre_n  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, plen) : plen;
		pay_n  = $urandom_range(0, 8);
		add_byte(8'h00);
		add_byte({6'd0, want_type});
		repeat (fill_n)
			add_byte((want_type == BT_SIGN) ? FILL_FF : 8'($urandom_range(1, 255)));
		add_byte(8'h00);
		for (int i = 0; i < pre_n; i++)
			add_byte(info_byte(want_digest, i));
		repeat (pay_n)
			add_byte(8'($urandom_range(0, 255)));
		damage = overlong ? 9 : $urandom_range(0, 9);
		case (damage)
			0: begin
				// pure noise
				blk_bytes.delete();
				repeat ($urandom_range(1, 20))
					add_byte(8'($urandom_range(0, 255)));
			end
			1, 2: begin
				k = $urandom_range(0, blk_bytes.size() - 1);
				blk_bytes[k] = 8'($urandom_range(0, 255));
			end
			3: begin
				// cut short
				k = $urandom_range(1, blk_bytes.size());
				while (blk_bytes.size() > k) void'(blk_bytes.pop_back());
			end
			default: ;
		endcase
	endtask

	// Sends blk_bytes; cut >= 0 places an idle register write before that byte
	task automatic send_block(input int cut);
		in_item_t it;
		for (int i = 0; i < blk_bytes.size(); i++) begin
			if (i == cut) begin
				settle();
				cfg_transfer($urandom_range(0, 1) ? CFG_DIGEST_MODE : CFG_BLOCK_TYPE,
					     2'($urandom_range(0, 3)), 1'b0);
			end
			it.data_byte = blk_bytes[i];
			it.last_byte = (i == blk_bytes.size() - 1);
			send_byte(it, 1'b0, '0);
		end
	endtask

	// Receiver: random stalls, result check against the oldest verdict
	always @(posedge clk) begin
		out_item_t want;
		if (!arst_n)
			out_ready <= 1'b0;
		else begin
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					$error("result with none pending: status %0d, offset %0d",
					       out_data.status, out_data.payload_offset);
					mismatches++;
				end else begin
					want = pending_results.pop_front();
					results_seen++;
					if (out_data.status < 5)
						status_hits[out_data.status]++;
					if (out_data.status !== want.status) begin
						$error("status: expected %0d, got %0d",
						       want.status, out_data.status);
						mismatches++;
					end
					if (out_data.payload_offset !== want.payload_offset) begin
						$error("payload_offset: expected %0d, got %0d",
						       want.payload_offset, out_data.payload_offset);
						mismatches++;
					end
				end
			end
			if (ready_hold > 0) begin
				ready_hold--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (stall_on && $urandom_range(0, 3) == 0)
					ready_hold = ($urandom_range(0, 9) == 0) ?
						$urandom_range(10, 40) : $urandom_range(1, 3);
			end
		end
	end

	// Watchdog: too long without any transfer ends the run
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("[rsa_pkcs1_unpad_checker] ERROR");
		$finish;
	end

	initial begin
		int rand_bytes, phase_no, nblk, cut;
		logic [1:0] t, d;
		bit overlong;
		clear_parse();
		rand_bytes = 0;
		phase_no   = 0;
		idle_on    = 1'b0;
		stall_on   = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: header errors, empty fill/payload, fill error, missing
		// separator, prefix end and mismatch, register change mid-block
		add_row(cfg_row(CFG_SPARE, 2'd3));
		add_row(end_row(8'h00, ST_HEADER, '0));
		add_row(byte_row(8'h00));
		add_row(byte_row(8'h01));
		add_row(end_row(8'h00, ST_OK, 10'd3));
		add_row(end_row(8'h5a, ST_HEADER, '0));
		add_row(byte_row(8'h00));
		add_row(byte_row(8'h01));
		add_row(end_row(8'hfe, ST_FILL, '0));
		add_row(byte_row(8'h00));
		add_row(byte_row(8'h01));
		add_row(end_row(8'hff, ST_NOSEP, '0));
		add_row(cfg_row(CFG_BLOCK_TYPE, 2'd2));
		add_row(cfg_row(CFG_DIGEST_MODE, DM_SHA1));
		add_row(byte_row(8'h00));
		add_row(byte_row(8'h02));
		add_row(byte_row(8'h7f));
		add_row(byte_row(8'h00));
		add_row(byte_row(8'h30));
		add_row(end_row(8'h21, ST_PREFIX, '0));
		add_row(cfg_row(CFG_DIGEST_MODE, DM_SHA256));
		add_row(byte_row(8'h00));
		add_row(byte_row(8'h02));
		add_row(byte_row(8'h00));
		add_row(end_row(8'h31, ST_PREFIX, '0));
		add_row(byte_row(8'h00));
		add_row(byte_row(8'h02));
		add_row(byte_row(8'h00));
		// mode 3 means no prefix, so the open prefix is already complete
		add_row(cfg_row(CFG_DIGEST_MODE, 2'd3));
		add_row(end_row(8'hab, ST_OK, 10'd3));
		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG) begin
				settle();
				cfg_transfer(dir_rows[i].reg_idx, dir_rows[i].reg_val, 1'b0);
			end else
				send_byte(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].result);
		end

		// Random phases, each with its own setting; the first ones hit the extremes
		while (rand_bytes < RANDOM_BYTES) begin
			settle();
			case (phase_no)
				0: begin t = BT_SIGN; d = DM_NONE;   end
				1: begin t = 2'd2;    d = DM_SHA256; end
				2: begin t = BT_SIGN; d = DM_SHA1;   end
				3: begin t = 2'd0;    d = 2'd3;      end
				4: begin t = 2'd3;    d = DM_SHA256; end
				default: begin
					t = ($urandom_range(0, 9) < 8) ? 2'($urandom_range(1, 2))
									: 2'($urandom_range(0, 3));
					d = 2'($urandom_range(0, 3));
				end
			endcase
			cfg_transfer(CFG_BLOCK_TYPE, t, 1'b1);
			cfg_transfer(CFG_DIGEST_MODE, d, 1'b0);
			idle_on  = (phase_no != 0) && ($urandom_range(0, 3) != 0);
			stall_on = (phase_no != 0) && ($urandom_range(0, 3) != 0);
			nblk = $urandom_range(3, 6);
			for (int b = 0; b < nblk; b++) begin
				overlong = (b == 0) && (phase_no == 2 || phase_no == 9);
				build_block(overlong);
				cut = (!overlong && blk_bytes.size() > 1 && $urandom_range(0, 5) == 0) ?
					$urandom_range(1, blk_bytes.size() - 1) : -1;
				send_block(cut);
				rand_bytes += blk_bytes.size();
			end
			phase_no++;
		end
		settle();

		$display("covered %0d bytes, %0d verdicts checked, %0d register writes, %0d phases",
			 bytes_sent, results_seen, cfg_writes, phase_no);
		$display("verdicts ok/header/fill/no-separator/prefix: %0d/%0d/%0d/%0d/%0d",
			 status_hits[0], status_hits[1], status_hits[2], status_hits[3],
			 status_hits[4]);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("[rsa_pkcs1_unpad_checker] OK");
		else
			$display("[rsa_pkcs1_unpad_checker] ERROR");
		$finish;
	end

endmodule
